/* src/isp_twfm_pkg.sv */
package isp_twfm_pkg;

  // Input transaction layout on s_tdata, lowest bit first
  localparam int unsigned CmdW      = 8;
  localparam int unsigned CountW    = 3;
  localparam int unsigned WordW     = 32;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 40;

  localparam int unsigned InCmdLsb    = 0;
  localparam int unsigned InReadBit   = 8;
  localparam int unsigned InCountLsb  = 9;
  localparam int unsigned InPayLsb    = 12;
  localparam int unsigned InSdaBit    = 44;

  // Tick kinds carried on s_tuser
  localparam logic FuncTick    = 1'b0;
  localparam logic FuncRequest = 1'b1;

  // Most significant bit of a shifted byte
  localparam logic [CmdW-1:0] MsbMask = 8'h80;

  // Pin and frame flags
  typedef struct packed {
    logic pend;
    logic drv;
    logic sda;
    logic scl;
  } pin_flags_t;

endpackage

/* src/isp_two_wire_frame_master.sv */
// Two-wire ISP frame master, one pin phase per tick transaction.
//
// Input channel (s_*): s_tuser = 1 starts a frame with the command, direction,
// byte count (saturated to MAX_BYTES) and write payload from s_tdata;
// s_tuser = 0 is a phase tick that advances the frame by one pin phase and
// carries the sampled data line level. A request while a frame is in progress
// is dropped and flagged as rejected.
// Output channel (m_*): exactly one result transaction per input transaction,
// carrying the pin levels after that phase, the busy flag, the frame_done
// pulse, the read word (valid only with frame_done) and the reject flag.
//
// A result is registered and valid in the cycle after input acceptance. Throughput is
// one transaction per cycle while the receiver takes each result: the phase state
// machine settles a whole phase in combinational logic ahead of the output register.
// When the receiver stalls, the output register holds its result and
// s_tready drops until that result is taken; no transaction is lost.
// Reset puts the machine idle, SCL low, SDA high and driven, and empties the
// output register.
module isp_two_wire_frame_master
  import isp_twfm_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [7:0] command, [8] is_read, [11:9] byte_count, [43:12] payload,
  // [44] sda_in, [47:45] zero
  input  logic [InDataW-1:0]  s_tdata,
  // [0] func
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
  // [4] frame_done, [36:5] read_word, [37] request_rejected, [39:38] zero
  output logic [OutDataW-1:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CMD,
    ST_WRITE,
    ST_READ,
    ST_END
  } stage_t;

  localparam logic [CountW:0] MaxBytesW = (CountW+1)'(MAX_BYTES);

  // Frame state
  stage_t            stage, stage_next;
  logic [1:0]        sub_phase, sub_phase_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [2:0]        byte_index, byte_index_next;
  logic [CmdW-1:0]   command_shift, command_shift_next;
  logic [WordW-1:0]  tx_shift, tx_shift_next;
  logic [WordW-1:0]  rx_shift, rx_shift_next;
  pin_flags_t        flags, flags_next;
  logic              read_mode, read_mode_next;
  logic [CountW-1:0] frame_count, frame_count_next;

  logic              done;
  logic              rejected;
  logic              accept;

  // Input fields
  logic              func;
  logic [CmdW-1:0]   in_command;
  logic              in_is_read;
  logic [CountW-1:0] in_count;
  logic [WordW-1:0]  in_payload;
  logic              in_sda;

  assign func       = s_tuser;
  assign in_command = s_tdata[InCmdLsb +: CmdW];
  assign in_is_read = s_tdata[InReadBit];
  assign in_count   = s_tdata[InCountLsb +: CountW];
  assign in_payload = s_tdata[InPayLsb +: WordW];
  assign in_sda     = s_tdata[InSdaBit];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Pick write byte k: byte (count-1-k) of the payload, zero above the word
  function automatic logic [CmdW-1:0] pick_byte(input logic [WordW-1:0] tx,
                                                input logic [CountW-1:0] cnt,
                                                input logic [2:0] k);
    logic [2:0] j;
    logic [CmdW-1:0] b;
    j = cnt - 3'd1 - k;
    case (j)
      3'd0:    b = tx[7:0];
      3'd1:    b = tx[15:8];
      3'd2:    b = tx[23:16];
      3'd3:    b = tx[31:24];
      default: b = '0;
    endcase
    return b;
  endfunction

  // Start or reject a frame on a request; advance one phase of the frame on a tick
  always_comb begin
    stage_next         = stage;
    sub_phase_next     = sub_phase;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    command_shift_next = command_shift;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    flags_next         = flags;
    read_mode_next     = read_mode;
    frame_count_next   = frame_count;
    done               = 1'b0;
    rejected           = 1'b0;

    if (func == FuncRequest) begin
      if (stage != ST_IDLE) begin
        rejected = 1'b1;
      end else begin
        frame_count_next   = ({1'b0, in_count} > MaxBytesW) ? MaxBytesW[CountW-1:0]
                                                            : in_count;
        read_mode_next     = in_is_read;
        command_shift_next = in_command;
        tx_shift_next      = in_payload;
        rx_shift_next      = '0;
        stage_next         = ST_START;
        sub_phase_next     = 2'd0;
        bit_index_next     = 3'd0;
        byte_index_next    = 3'd0;
      end
    end else if (stage != ST_IDLE) begin
      // Pull SDA low again after a byte's tail phase
      if (flags.pend) begin
        flags_next.pend = 1'b0;
        flags_next.drv  = 1'b1;
        flags_next.sda  = 1'b0;
      end
      unique case (stage)
        ST_START: begin
          case (sub_phase)
            2'd0:    flags_next.sda = 1'b1;
            2'd1:    flags_next.scl = 1'b1;
            2'd2:    flags_next.sda = 1'b0;
            default: flags_next.scl = 1'b0;
          endcase
          if (sub_phase == 2'd3) begin
            stage_next     = ST_CMD;
            sub_phase_next = 2'd0;
            bit_index_next = 3'd0;
          end else begin
            sub_phase_next = sub_phase + 2'd1;
          end
        end
        ST_CMD, ST_WRITE: begin
          case (sub_phase)
            2'd0: begin
              flags_next.scl = 1'b0;
              sub_phase_next = 2'd1;
            end
            2'd1: begin
              flags_next.sda     = (command_shift & MsbMask) != '0;
              command_shift_next = {command_shift[CmdW-2:0], 1'b0};
              sub_phase_next     = 2'd2;
            end
            2'd2: begin
              flags_next.scl = 1'b1;
              if (bit_index == 3'd7) begin
                sub_phase_next = 2'd3;
              end else begin
                bit_index_next = bit_index + 3'd1;
                sub_phase_next = 2'd0;
              end
            end
            default: begin
              flags_next.scl  = 1'b0;
              flags_next.pend = 1'b1;
              if (stage == ST_CMD) begin
                byte_index_next = 3'd0;
                if (frame_count == '0) begin
                  stage_next     = ST_END;
                  sub_phase_next = 2'd0;
                end else if (read_mode) begin
                  stage_next     = ST_READ;
                  sub_phase_next = 2'd0;
                  bit_index_next = 3'd0;
                end else begin
                  stage_next         = ST_WRITE;
                  command_shift_next = pick_byte(tx_shift, frame_count, 3'd0);
                  bit_index_next     = 3'd0;
                  sub_phase_next     = 2'd0;
                end
              end else if ({1'b0, byte_index} + 4'd1 >= {1'b0, frame_count}) begin
                stage_next     = ST_END;
                sub_phase_next = 2'd0;
              end else begin
                byte_index_next    = byte_index + 3'd1;
                sub_phase_next     = 2'd0;
                bit_index_next     = 3'd0;
                command_shift_next = pick_byte(tx_shift, frame_count,
                                               byte_index + 3'd1);
              end
            end
          endcase
        end
        ST_READ: begin
          if (sub_phase == 2'd0) begin
            flags_next.drv = 1'b0;
            flags_next.scl = 1'b0;
            bit_index_next = 3'd0;
            sub_phase_next = 2'd1;
          end else if (sub_phase == 2'd1) begin
            flags_next.scl = 1'b1;
            sub_phase_next = 2'd2;
          end else begin
            // Sample at the end of the SCL-high phase
            rx_shift_next  = {rx_shift[WordW-2:0], in_sda};
            flags_next.scl = 1'b0;
            if (bit_index == 3'd7) begin
              flags_next.pend = 1'b1;
              if ({1'b0, byte_index} + 4'd1 >= {1'b0, frame_count}) begin
                stage_next     = ST_END;
                sub_phase_next = 2'd0;
              end else begin
                byte_index_next = byte_index + 3'd1;
                sub_phase_next  = 2'd0;
                bit_index_next  = 3'd0;
              end
            end else begin
              bit_index_next = bit_index + 3'd1;
              sub_phase_next = 2'd1;
            end
          end
        end
        ST_END: begin
          case (sub_phase)
            2'd0:    flags_next.scl = 1'b0;
            2'd1:    flags_next.sda = 1'b0;
            2'd2:    flags_next.scl = 1'b1;
            default: flags_next.sda = 1'b1;
          endcase
          if (sub_phase == 2'd3) begin
            done            = 1'b1;
            stage_next      = ST_IDLE;
            sub_phase_next  = 2'd0;
            bit_index_next  = 3'd0;
            byte_index_next = 3'd0;
          end else begin
            sub_phase_next = sub_phase + 2'd1;
          end
        end
        default: begin
          stage_next = ST_IDLE;
        end
      endcase
    end
  end

  // Hold state and the result register; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_IDLE;
      sub_phase     <= 2'd0;
      bit_index     <= 3'd0;
      byte_index    <= 3'd0;
      command_shift <= '0;
      tx_shift      <= '0;
      rx_shift      <= '0;
      flags         <= '{pend: 1'b0, drv: 1'b1, sda: 1'b1, scl: 1'b0};
      read_mode     <= 1'b0;
      frame_count   <= '0;
      m_tvalid      <= 1'b0;
    end else if (accept) begin
      stage         <= stage_next;
      sub_phase     <= sub_phase_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      command_shift <= command_shift_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      flags         <= flags_next;
      read_mode     <= read_mode_next;
      frame_count   <= frame_count_next;
      m_tvalid      <= 1'b1;
    end else if (m_tready) begin
      m_tvalid      <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00,
                  rejected,
                  done ? rx_shift_next : {WordW{1'b0}},
                  done,
                  stage_next != ST_IDLE,
                  flags_next.drv,
                  flags_next.sda,
                  flags_next.scl};
    end
  end

endmodule
